### hdl/assert_macros.svh
// Assertion macros shared by the peak finder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define GLPF_ASSERT(label, ck, rn, expr) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
        else $error("peak finder invariant violated");

// Check that a condition holds in the same cycle as a trigger.
`define GLPF_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("peak finder implication violated");

// Check that a condition holds in the cycle after a trigger.
`define GLPF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("peak finder sequence violated");

`endif

### hdl/glpf_pkg.sv
// Shared types and constants of the grid local peak finder.
package glpf_pkg;

    // Configuration port
    localparam int CFG_WIDTH       = 6;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_COLS = 1'd1;

    // Reported coordinates are always five bits wide
    localparam int COORD_WIDTH = 5;

    // At most three reports per sample; report queue sizing
    localparam int RUN_MAX     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Position of the current sample within the grid
    typedef struct packed {
        logic r_gt0;
        logic r_gt1;
        logic r_last;
        logic c_gt0;
        logic c_gt1;
        logic c_last;
    } pos_flags_t;

    // One peak report word
    typedef struct packed {
        logic [COORD_WIDTH-1:0] row;
        logic [COORD_WIDTH-1:0] col;
        logic                   last;
    } report_t;

endpackage

### hdl/glpf_ram.sv
// Generic single write port, single read port RAM with registered read.
module glpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read the old contents on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/glpf_window.sv
// Grid position counters, line buffers and neighbor window of the peak finder.
`include "assert_macros.svh"

module glpf_window #(
    parameter int MAX_ROWS     = 32,
    parameter int MAX_COLS     = 32,
    parameter int SAMPLE_WIDTH = 16,
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RSZ = RW + 1,
    localparam int CSZ = CW + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           restart,
    input  logic signed [SAMPLE_WIDTH-1:0] height,
    input  logic [RSZ-1:0]                 rows_eff,
    input  logic [CSZ-1:0]                 cols_eff,
    output glpf_pkg::pos_flags_t           flags,
    output logic [RW-1:0]                  row,
    output logic [CW-1:0]                  col,
    output logic signed [SAMPLE_WIDTH-1:0] mid_here,
    output logic signed [SAMPLE_WIDTH-1:0] mid_right,
    output logic signed [SAMPLE_WIDTH-1:0] up_here,
    output logic signed [SAMPLE_WIDTH-1:0] up_left,
    output logic signed [SAMPLE_WIDTH-1:0] left1,
    output logic signed [SAMPLE_WIDTH-1:0] left2
);

    import glpf_pkg::*;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic signed [SAMPLE_WIDTH-1:0] left1_reg, left2_reg;
    logic signed [SAMPLE_WIDTH-1:0] mid_prev_reg;
    logic signed [SAMPLE_WIDTH-1:0] up_left_reg;
    logic          mid_byp_reg, up_byp_reg;

    logic [CW-1:0]  col_adv;
    logic [CSZ-1:0] mid_ahead;
    logic [CW-1:0]  mid_raddr;
    logic signed [SAMPLE_WIDTH-1:0] mid_rdata, up_rdata;
    logic           one_col;

    // Position flags of the current sample
    always_comb
    begin
        flags.r_gt0  = (row_reg != '0);
        flags.r_gt1  = (row_reg > RW'(1));
        flags.r_last = ({1'b0, row_reg} == (rows_eff - RSZ'(1)));
        flags.c_gt0  = (col_reg != '0);
        flags.c_gt1  = (col_reg > CW'(1));
        flags.c_last = ({1'b0, col_reg} == (cols_eff - CSZ'(1)));
    end

    // Advance in raster order, wrap at the end of the frame
    always_comb
    begin
        col_adv  = flags.c_last ? '0 : (col_reg + CW'(1));
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            col_next = col_adv;
            if (flags.c_last)
            begin
                row_next = flags.r_last ? '0 : (row_reg + RW'(1));
            end
        end
    end

    // Prefetch the middle line one column ahead of the next sample
    always_comb
    begin
        mid_ahead = {1'b0, col_adv} + CSZ'(1);
        mid_raddr = (mid_ahead == cols_eff) ? '0 : mid_ahead[CW-1:0];
    end

    glpf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_mid_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (height),
        .re    (accept),
        .raddr (mid_raddr),
        .rdata (mid_rdata)
    );

    glpf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_up_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (mid_here),
        .re    (accept),
        .raddr (col_adv),
        .rdata (up_rdata)
    );

    // Forward a word written in the same cycle it was read
    assign one_col   = (cols_eff == CSZ'(1));
    assign mid_right = mid_byp_reg ? left1_reg : mid_rdata;
    assign up_here   = up_byp_reg ? up_left_reg : up_rdata;
    assign mid_here  = one_col ? left1_reg : mid_prev_reg;
    assign up_left   = up_left_reg;
    assign left1     = left1_reg;
    assign left2     = left2_reg;
    assign row       = row_reg;
    assign col       = col_reg;

    // Hold counters; restart the frame on a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (restart)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Shift the sample history on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left1_reg    <= '0;
            left2_reg    <= '0;
            mid_prev_reg <= '0;
            up_left_reg  <= '0;
            mid_byp_reg  <= 1'b0;
            up_byp_reg   <= 1'b0;
        end
        else if (accept)
        begin
            left1_reg    <= height;
            left2_reg    <= left1_reg;
            mid_prev_reg <= mid_right;
            up_left_reg  <= mid_here;
            mid_byp_reg  <= (mid_raddr == col_reg);
            up_byp_reg   <= (col_adv == col_reg);
        end
    end

    `GLPF_ASSERT(a_pos_in_grid, clk, rst_n,
        ({1'b0, row_reg} < rows_eff) && ({1'b0, col_reg} < cols_eff))
    `GLPF_ASSERT_NEXT(a_row_wrap, clk, rst_n,
        accept && !restart && flags.c_last, col_reg == '0)

endmodule

### hdl/glpf_peak_eval.sv
// Four-neighbor peak tests for the up to three cells completed by one sample.
module glpf_peak_eval #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ROW_W        = 5,
    parameter int COL_W        = 5
) (
    input  glpf_pkg::pos_flags_t           flags,
    input  logic [ROW_W-1:0]               row,
    input  logic [COL_W-1:0]               col,
    input  logic signed [SAMPLE_WIDTH-1:0] height,
    input  logic signed [SAMPLE_WIDTH-1:0] mid_here,
    input  logic signed [SAMPLE_WIDTH-1:0] mid_right,
    input  logic signed [SAMPLE_WIDTH-1:0] up_here,
    input  logic signed [SAMPLE_WIDTH-1:0] up_left,
    input  logic signed [SAMPLE_WIDTH-1:0] left1,
    input  logic signed [SAMPLE_WIDTH-1:0] left2,
    output logic [glpf_pkg::RUN_MAX-1:0]   hit,
    output glpf_pkg::report_t              entry [glpf_pkg::RUN_MAX]
);

    import glpf_pkg::*;

    logic [ROW_W-1:0]             row_up;
    logic [COL_W-1:0]             col_left;
    logic [ROW_W+COORD_WIDTH-1:0] row_ext, row_up_ext;
    logic [COL_W+COORD_WIDTH-1:0] col_ext, col_left_ext;

    // Test each completed cell against its existing neighbors
    always_comb
    begin
        // cell above the current sample
        hit[0] = flags.r_gt0
                 && !(flags.r_gt1 && (mid_here < up_here))
                 && !(mid_here < height)
                 && !(flags.c_gt0 && (mid_here < up_left))
                 && !(!flags.c_last && (mid_here < mid_right));
        // last row: cell to the left of the current sample
        hit[1] = flags.r_last && flags.c_gt0
                 && !(flags.r_gt0 && (left1 < up_left))
                 && !(flags.c_gt1 && (left1 < left2))
                 && !(left1 < height);
        // last row and last column: the current sample itself
        hit[2] = flags.r_last && flags.c_last
                 && !(flags.r_gt0 && (height < mid_here))
                 && !(flags.c_gt0 && (height < left1));
    end

    // Truncate coordinates to the report width
    always_comb
    begin
        row_up       = row - ROW_W'(1);
        col_left     = col - COL_W'(1);
        row_ext      = {{COORD_WIDTH{1'b0}}, row};
        row_up_ext   = {{COORD_WIDTH{1'b0}}, row_up};
        col_ext      = {{COORD_WIDTH{1'b0}}, col};
        col_left_ext = {{COORD_WIDTH{1'b0}}, col_left};
    end

    // Build report words in raster order, mark the last of the run
    always_comb
    begin
        entry[0].row  = row_up_ext[COORD_WIDTH-1:0];
        entry[0].col  = col_ext[COORD_WIDTH-1:0];
        entry[0].last = !hit[1] && !hit[2];
        entry[1].row  = row_ext[COORD_WIDTH-1:0];
        entry[1].col  = col_left_ext[COORD_WIDTH-1:0];
        entry[1].last = !hit[2];
        entry[2].row  = row_ext[COORD_WIDTH-1:0];
        entry[2].col  = col_ext[COORD_WIDTH-1:0];
        entry[2].last = 1'b1;
    end

endmodule

### hdl/glpf_report_fifo.sv
// Report queue: takes up to three words per cycle, delivers one per cycle while out_ready is high.
`include "assert_macros.svh"

module glpf_report_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [glpf_pkg::RUN_MAX-1:0] push,
    input  glpf_pkg::report_t            entry [glpf_pkg::RUN_MAX],
    output logic                         room,
    output logic                         out_valid,
    input  logic                         out_ready,
    output glpf_pkg::report_t            out_entry
);

    import glpf_pkg::*;

    report_t                mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] offset [RUN_MAX];
    logic [QUEUE_CNT_W-1:0] npush;
    logic                   pop;

    // Pack the pushed words into consecutive slots
    always_comb
    begin
        offset[0] = '0;
        npush     = QUEUE_CNT_W'(push[0]);
        for (int k = 1; k < RUN_MAX; k++)
        begin
            offset[k] = npush[QUEUE_PTR_W-1:0];
            npush     = npush + QUEUE_CNT_W'(push[k]);
        end
    end

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_entry = mem[rd_ptr_reg];
    assign room      = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - RUN_MAX));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + npush[QUEUE_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + npush - QUEUE_CNT_W'(pop);
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RUN_MAX; k++)
        begin
            if (push[k])
            begin
                mem[wr_ptr_reg + offset[k]] <= entry[k];
            end
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `GLPF_ASSERT(a_count_bound, clk, rst_n, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
    `GLPF_ASSERT(a_ptr_match, clk, rst_n,
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0])
    `GLPF_ASSERT_IMPL(a_no_overflow, clk, rst_n,
        push != '0, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - RUN_MAX))

endmodule

### hdl/grid_local_peak_finder.sv
// Top level of the grid local peak finder. Height samples of a grid_rows by
// grid_cols grid enter in raster order, one per clock, and every cell that is
// greater than or equal to each of its existing up, down, left and right
// neighbors is reported as a (row, col) word once its last neighbor arrived;
// last_of_run marks the final report caused by one sample. Two line buffer
// RAMs of MAX_COLS words, read one column ahead, let every row but the last
// run at one sample per clock while out_ready stays high, with at most one report
// per sample. In the last row a sample can cause two reports (three at the final
// column), and the output port, giving one report per clock while out_ready is
// high, sets the pace there. A four-word report queue parts input and output;
// the input stalls while fewer than three queue slots are free. A register
// write restarts the frame at cell (0,0); sizes of 0 count as 1 and sizes
// above MAX_ROWS or MAX_COLS count as that maximum. No clearing pass is needed
// after reset: line buffer words are only used once the current frame wrote them.
module grid_local_peak_finder #(
    parameter int MAX_ROWS     = 32,
    parameter int MAX_COLS     = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         height,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [glpf_pkg::COORD_WIDTH-1:0]       peak_row,
    output logic [glpf_pkg::COORD_WIDTH-1:0]       peak_col,
    output logic                                   last_of_run,
    input  logic                                   cfg_we,
    input  logic [glpf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [glpf_pkg::CFG_WIDTH-1:0]         cfg_data
);

    import glpf_pkg::*;

    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RSZ  = RW + 1;
    localparam int CSZ  = CW + 1;
    localparam int CMPR = (RSZ > CFG_WIDTH) ? RSZ : CFG_WIDTH;
    localparam int CMPC = (CSZ > CFG_WIDTH) ? CSZ : CFG_WIDTH;

    logic [CFG_WIDTH-1:0] grid_rows_reg, grid_cols_reg;
    logic [CMPR-1:0]      rows_cmp;
    logic [CMPC-1:0]      cols_cmp;
    logic [RSZ-1:0]       rows_eff;
    logic [CSZ-1:0]       cols_eff;

    logic                 accept;
    pos_flags_t           flags;
    logic [RW-1:0]        row;
    logic [CW-1:0]        col;
    logic signed [SAMPLE_WIDTH-1:0] mid_here, mid_right, up_here, up_left;
    logic signed [SAMPLE_WIDTH-1:0] left1, left2;
    logic [RUN_MAX-1:0]   hit;
    report_t              entry [RUN_MAX];
    report_t              out_entry;

    // Hold the size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= CFG_WIDTH'(1);
            grid_cols_reg <= CFG_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Clamp sizes into the supported range
    always_comb
    begin
        rows_cmp = CMPR'(grid_rows_reg);
        if (rows_cmp == '0)
        begin
            rows_cmp = CMPR'(1);
        end
        else if (rows_cmp > CMPR'(MAX_ROWS))
        begin
            rows_cmp = CMPR'(MAX_ROWS);
        end
        cols_cmp = CMPC'(grid_cols_reg);
        if (cols_cmp == '0)
        begin
            cols_cmp = CMPC'(1);
        end
        else if (cols_cmp > CMPC'(MAX_COLS))
        begin
            cols_cmp = CMPC'(MAX_COLS);
        end
        rows_eff = rows_cmp[RSZ-1:0];
        cols_eff = cols_cmp[CSZ-1:0];
    end

    assign accept = in_valid && in_ready;

    glpf_window #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .restart   (cfg_we),
        .height    (height),
        .rows_eff  (rows_eff),
        .cols_eff  (cols_eff),
        .flags     (flags),
        .row       (row),
        .col       (col),
        .mid_here  (mid_here),
        .mid_right (mid_right),
        .up_here   (up_here),
        .up_left   (up_left),
        .left1     (left1),
        .left2     (left2)
    );

    glpf_peak_eval #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ROW_W        (RW),
        .COL_W        (CW)
    ) u_peak_eval (
        .flags     (flags),
        .row       (row),
        .col       (col),
        .height    (height),
        .mid_here  (mid_here),
        .mid_right (mid_right),
        .up_here   (up_here),
        .up_left   (up_left),
        .left1     (left1),
        .left2     (left2),
        .hit       (hit),
        .entry     (entry)
    );

    glpf_report_fifo u_report_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hit & {RUN_MAX{accept}}),
        .entry     (entry),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_entry (out_entry)
    );

    // Drive the result word
    assign peak_row    = out_entry.row;
    assign peak_col    = out_entry.col;
    assign last_of_run = out_entry.last;

endmodule
